// ----- sv/tcht_pkg.sv -----
// Package with the types, codes and hash functions of the connection table.
`default_nettype none
package tcht_pkg;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_GET  = 2'd1,
    OP_DEL  = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_RSVD = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_RUN   = 2'd1,
    BK_CMP   = 2'd2
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [3:0]  new_state;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] state_out;
  } rsp_t;

  typedef struct packed {
    req_t        req;
    logic [31:0] hash;
  } qent_t;

  typedef struct packed {
    logic  full;
    logic  empty;
  } qstat_t;

  localparam int unsigned QDEPTH = 2;

  function automatic logic [31:0] mix32(input logic [31:0] x);
    logic [31:0] v;
    v = x;
    v = v ^ ~(v << 15);
    v = v + (v >> 10);
    v = v ^ (v << 3);
    v = v + ~(v >> 16);
    return v;
  endfunction

  function automatic logic [31:0] mix_pair(input logic [31:0] a, input logic [31:0] b);
    return mix32((a << 3) ^ (b >> 2) ^ (a >> 3) ^ (b << 4));
  endfunction

endpackage
`default_nettype wire

// ----- sv/tcp_connection_hash_table_top.sv -----
// Top level of the TCP connection table: front end, queue and bucket back end.
//
//   Channel   Handshake          Payload
//   request   start, busy        req_i  (tcht_pkg::req_t)
//   result    done_o strobe      rsp_o  (tcht_pkg::rsp_t)
//
// After reset the table clears every bucket, one per cycle, with busy high.
// Each request is registered in the hash front end and queued; the back end does the
// registered bucket read in its run state and the compare and write-back in its
// compare state, and pops no new request from the queue until that compare is done.
// The result appears for one cycle on done_o; the receiver cannot stall it.
`default_nettype none
module tcp_connection_hash_table_top #(
  parameter int unsigned BUCKETS    = 1024,
  parameter int unsigned WAYS       = 4,
  parameter int unsigned STATE_BITS = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire tcht_pkg::req_t req_i,
  output logic                done_o,
  output tcht_pkg::rsp_t      rsp_o
);

  logic             push, pop, clearing;
  tcht_pkg::qent_t  push_ent, head_ent;
  tcht_pkg::qstat_t qstat;

  tcht_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .req_i   (req_i),
    .hold_i  (clearing),
    .q_full_i(qstat.full),
    .busy    (busy),
    .push_o  (push),
    .ent_o   (push_ent)
  );

  tcht_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .ent_i (push_ent),
    .pop_i (pop),
    .ent_o (head_ent),
    .stat_o(qstat)
  );

  tcht_back #(
    .BUCKETS   (BUCKETS),
    .WAYS      (WAYS),
    .STATE_BITS(STATE_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ent_i     (head_ent),
    .qstat_i   (qstat),
    .pop_o     (pop),
    .clearing_o(clearing),
    .done_o    (done_o),
    .rsp_o     (rsp_o)
  );

endmodule
`default_nettype wire

// ----- sv/tcht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tcht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- sv/tcht_front.sv -----
// Front end: accepts requests and computes the four-tuple hash in two steps.
`default_nettype none
module tcht_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire tcht_pkg::req_t req_i,
  input  wire logic           hold_i,
  input  wire logic           q_full_i,
  output logic                busy,
  output logic                push_o,
  output tcht_pkg::qent_t     ent_o
);

  logic           vld_q, vld_d;
  tcht_pkg::req_t req_q;
  logic [31:0]    h1_q;
  logic           accept;

  assign push_o = vld_q && !q_full_i;
  assign busy   = hold_i || (vld_q && q_full_i);
  assign accept = start && !busy;

  assign ent_o.req  = req_q;
  assign ent_o.hash = tcht_pkg::mix_pair(h1_q, {req_q.dst_port, req_q.src_port});

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      h1_q  <= tcht_pkg::mix_pair(req_i.src_ip, req_i.dst_ip);
    end
  end

endmodule
`default_nettype wire

// ----- sv/tcht_queue.sv -----
// Two-entry queue between the hashing front end and the table back end.
`default_nettype none
module tcht_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tcht_pkg::qent_t ent_i,
  input  wire logic            pop_i,
  output tcht_pkg::qent_t      ent_o,
  output tcht_pkg::qstat_t     stat_o
);

  tcht_pkg::qent_t mem_q [tcht_pkg::QDEPTH];
  logic            wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == 2'(tcht_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == 2'd0);
  assign ent_o        = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q + 1'(push_i);
    rptr_d = rptr_q + 1'(pop_i);
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= ent_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i)
    else $error("Queue written while full.");
`endif

endmodule
`default_nettype wire

// ----- sv/tcht_back.sv -----
// Back end: clears the table; per request reads and compares a bucket, writing it back if changed.
`default_nettype none
module tcht_back #(
  parameter int unsigned BUCKETS    = 1024,
  parameter int unsigned WAYS       = 4,
  parameter int unsigned STATE_BITS = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tcht_pkg::qent_t  ent_i,
  input  wire tcht_pkg::qstat_t qstat_i,
  output logic                  pop_o,
  output logic                  clearing_o,
  output logic                  done_o,
  output tcht_pkg::rsp_t        rsp_o
);

  localparam int unsigned BW  = $clog2(BUCKETS);
  localparam int unsigned EW  = STATE_BITS + 97;
  localparam int unsigned RW  = WAYS * EW;

  tcht_pkg::back_state_e state_q, state_d;
  logic [BW-1:0]         clr_q, clr_d;
  tcht_pkg::qent_t       cur_q, cur_d;
  logic                  done_d;
  tcht_pkg::rsp_t        rsp_d;

  logic                  we;
  logic [BW-1:0]         waddr;
  logic [RW-1:0]         wdata;
  logic [BW-1:0]         raddr;
  logic [RW-1:0]         rdata;

  logic [RW-1:0]         row_new;
  logic                  row_we;
  tcht_pkg::rsp_t        row_rsp;

  tcht_ram #(
    .WIDTH(RW),
    .DEPTH(BUCKETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    logic                  found;
    logic                  free_found;
    logic [EW-1:0]         e;
    logic [EW-1:0]         ne;
    logic [63:0]           addr;
    logic [31:0]           ports;
    logic [STATE_BITS-1:0] nst;
    addr       = {cur_q.req.dst_ip, cur_q.req.src_ip};
    ports      = {cur_q.req.dst_port, cur_q.req.src_port};
    nst        = STATE_BITS'(cur_q.req.new_state);
    ne         = {1'b1, addr, ports, nst};
    found      = 1'b0;
    free_found = 1'b0;
    row_new    = rdata;
    row_we     = 1'b0;
    row_rsp    = '{status: tcht_pkg::ST_MISS, state_out: 4'd0};
    for (int w = 0; w < WAYS; w++) begin
      e = rdata[w*EW +: EW];
      if (e[EW-1] && !found && e[EW-2 -: 96] == {addr, ports}) begin
        found = 1'b1;
        case (cur_q.req.op)
          tcht_pkg::OP_SET: begin
            row_new[w*EW +: STATE_BITS] = nst;
            row_we = 1'b1;
            row_rsp.status = tcht_pkg::ST_OK;
          end
          tcht_pkg::OP_GET: begin
            row_rsp.status    = tcht_pkg::ST_OK;
            row_rsp.state_out = 4'(e[STATE_BITS-1:0]);
          end
          tcht_pkg::OP_DEL: begin
            row_new[w*EW + EW - 1] = 1'b0;
            row_we = 1'b1;
            row_rsp.status = tcht_pkg::ST_OK;
          end
          default: ;
        endcase
      end
    end
    if (!found && cur_q.req.op == tcht_pkg::OP_SET) begin
      row_rsp.status = tcht_pkg::ST_FULL;
      for (int w = 0; w < WAYS; w++) begin
        if (!rdata[w*EW + EW - 1] && !free_found) begin
          free_found = 1'b1;
          row_new[w*EW +: EW] = ne;
          row_we = 1'b1;
          row_rsp.status = tcht_pkg::ST_OK;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcht_pkg::BK_CLEAR: if (clr_q == BW'(BUCKETS - 1)) state_d = tcht_pkg::BK_RUN;
      tcht_pkg::BK_RUN:   if (!qstat_i.empty) state_d = tcht_pkg::BK_CMP;
      tcht_pkg::BK_CMP:   state_d = tcht_pkg::BK_RUN;
      default:            state_d = tcht_pkg::BK_CLEAR;
    endcase
  end

  always_comb begin
    clearing_o = 1'b0;
    pop_o      = 1'b0;
    we         = 1'b0;
    waddr      = cur_q.hash[BW-1:0];
    wdata      = row_new;
    raddr      = ent_i.hash[BW-1:0];
    clr_d      = clr_q;
    cur_d      = cur_q;
    done_d     = 1'b0;
    rsp_d      = row_rsp;
    unique case (state_q)
      tcht_pkg::BK_CLEAR: begin
        clearing_o = 1'b1;
        we         = 1'b1;
        waddr      = clr_q;
        wdata      = '0;
        clr_d      = clr_q + 1'b1;
      end
      tcht_pkg::BK_RUN: begin
        pop_o = !qstat_i.empty;
        cur_d = ent_i;
      end
      tcht_pkg::BK_CMP: begin
        we     = row_we;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcht_pkg::BK_CLEAR;
      clr_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_o  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    rsp_o <= rsp_d;
  end

`ifndef SYNTHESIS
  a_done_after_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == tcht_pkg::BK_CMP)
    else $error("Result strobe without a compare cycle.");
  a_pop_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == tcht_pkg::BK_RUN && !qstat_i.empty)
    else $error("Queue popped outside the run state.");
  a_cmp_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcht_pkg::BK_CMP |-> $past(pop_o))
    else $error("Compare cycle without a popped request.");
`endif

endmodule
`default_nettype wire
